FILE: src/fma24_pkg.sv
package fma24_pkg;

   typedef enum logic {
      OP_MUL = 1'b0,
      OP_ADD = 1'b1
   } op_type;

   localparam int MANT_W = 16;
   localparam int EXP_W  = 8;
   localparam int PROD_W = 32;

   typedef struct packed {
      op_type            operation;
      logic signed [15:0] a_mantissa;
      logic signed [7:0]  a_exponent;
      logic signed [15:0] b_mantissa;
      logic signed [7:0]  b_exponent;
   } req_type;

   typedef struct packed {
      logic signed [15:0] result_mantissa;
      logic signed [7:0]  result_exponent;
   } rsp_type;

endpackage

FILE: src/fma24_if.sv
interface fma24_req_if import fma24_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface fma24_rsp_if import fma24_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: src/fma24_norm.sv
module fma24_norm import fma24_pkg::*; (
   input  logic signed [31:0] mant,
   input  logic        [7:0]  expo,
   output rsp_type            result
);
   logic [31:0] mag;
   logic [4:0]  shift;
   logic [31:0] smag;
   logic [15:0] mant_out;

   always_comb begin
      mag   = mant[31] ? (~mant + 32'd1) : mant;
      shift = 5'd0;
      for (int i = 15; i < 32; i++) begin
         if (mag[i]) shift = 5'(i - 14);
      end
      smag     = mag >> shift;
      mant_out = mant[31] ? (~smag[15:0] + 16'd1) : smag[15:0];
      result.result_mantissa = mant_out;
      result.result_exponent = expo + {3'd0, shift};
   end
endmodule

FILE: src/float24_mul_add_unit.sv
// Channel | Dir | Payload
// req     | in  | operation, a_mantissa, a_exponent, b_mantissa, b_exponent
// rsp     | out | result_mantissa, result_exponent
//
// rsp.valid follows a req accept through the input register, then the result
// register, so the earliest rsp accept follows the load of the result register.
// One item per cycle sustained; both stages advance whenever the result stage is
// free or being taken. Synchronous active-high reset clears the valid bits only.
// Stalled rsp holds the full stages; req.ready drops only when both are full.
module float24_mul_add_unit import fma24_pkg::*; (
   input logic   clock,
   input logic   reset,
   fma24_req_if.sink   req,
   fma24_rsp_if.source rsp
);
   req_type in_ff;
   logic    in_vld_ff;
   rsp_type out_ff;
   logic    out_vld_ff;
   logic    adv_out, adv_in;

   logic signed [31:0] prod;
   logic signed [7:0]  emax;
   logic [7:0]  da, db;
   logic signed [16:0] sa, sb;
   logic signed [31:0] pre_mant;
   logic [7:0]  pre_exp;
   logic [15:0] maga, magb;
   rsp_type     norm_res;

   assign adv_out   = !out_vld_ff || rsp.ready;
   assign adv_in    = adv_out || !in_vld_ff;
   assign req.ready = adv_in;
   assign rsp.valid = out_vld_ff;
   assign rsp.payload = out_ff;

   // Multiply, or align to the larger exponent and add, truncating toward zero.
   always_comb begin
      prod = in_ff.a_mantissa * in_ff.b_mantissa;
      emax = (in_ff.a_exponent > in_ff.b_exponent) ? in_ff.a_exponent : in_ff.b_exponent;
      da   = 8'(emax - in_ff.a_exponent);
      db   = 8'(emax - in_ff.b_exponent);
      maga = in_ff.a_mantissa[15] ? 16'(-in_ff.a_mantissa) : in_ff.a_mantissa;
      magb = in_ff.b_mantissa[15] ? 16'(-in_ff.b_mantissa) : in_ff.b_mantissa;
      maga = (da >= 8'd16) ? 16'd0 : maga >> da[3:0];
      magb = (db >= 8'd16) ? 16'd0 : magb >> db[3:0];
      sa = in_ff.a_mantissa[15] ? -$signed({1'b0, maga}) : $signed({1'b0, maga});
      sb = in_ff.b_mantissa[15] ? -$signed({1'b0, magb}) : $signed({1'b0, magb});
      if (in_ff.operation == OP_MUL) begin
         pre_mant = prod;
         pre_exp  = 8'(in_ff.a_exponent + in_ff.b_exponent);
      end else begin
         pre_mant = 32'(sa + sb);
         pre_exp  = emax;
      end
   end

   fma24_norm u_norm (.mant(pre_mant), .expo(pre_exp), .result(norm_res));

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (adv_in) in_vld_ff <= req.valid;
         if (adv_out) out_vld_ff <= in_vld_ff;
      end
      if (adv_in && req.valid) in_ff <= req.payload;
      if (adv_out && in_vld_ff) out_ff <= norm_res;
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !rsp.ready |=> out_vld_ff && $stable(out_ff))
      else $error("result dropped under stall");
   a_move: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && adv_out |=> out_vld_ff)
      else $error("item lost between stages");
   a_range: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> out_ff.result_mantissa != 16'sh8000)
      else $error("mantissa not normalised");
endmodule

FILE: tb/tb_float24_mul_add_unit.sv
`timescale 1ns / 100ps

module tb_float24_mul_add_unit;
   import fma24_pkg::*;

   logic clock;
   logic reset;

   fma24_req_if req_ch ();
   fma24_rsp_if rsp_ch ();

   float24_mul_add_unit uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   // Directed row: operand pair plus an optional typed-in answer.
   typedef struct {
      req_type item;
      bit      known;
      rsp_type answer;
   } vector_row;

   rsp_type   pending_results[$];
   int        error_count;
   int        send_idle_pct;
   int        recv_idle_pct;
   vector_row vectors[$];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("[float24_mul_add_unit] ERROR");
      $finish;
   end

   // Halve toward zero until the magnitude fits in 15 bits.
   function automatic rsp_type normalize_result(longint mant, logic [7:0] expo);
      rsp_type r;
      while (mant > 32767 || mant < -32767) begin
         mant = mant / 2;
         expo = expo + 8'd1;
      end
      r.result_mantissa = mant[15:0];
      r.result_exponent = expo;
      return r;
   endfunction

   function automatic longint shift_to_zero(longint v, int d);
      longint mag;
      if (d >= 31) return 0;
      mag = (v < 0) ? -v : v;
      mag = mag >>> d;
      return (v < 0) ? -mag : mag;
   endfunction

   function automatic rsp_type compute_mul_add(req_type r);
      int        ea, eb, top;
      longint    ma, mb;
      logic [7:0] esum;
      ea = r.a_exponent;
      eb = r.b_exponent;
      ma = r.a_mantissa;
      mb = r.b_mantissa;
      if (r.operation == OP_MUL) begin
         esum = r.a_exponent + r.b_exponent;
         return normalize_result(ma * mb, esum);
      end
      top = (ea > eb) ? ea : eb;
      return normalize_result(shift_to_zero(ma, top - ea) + shift_to_zero(mb, top - eb),
                              top[7:0]);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d, want %0d", what, got, want);
      error_count++;
   endtask

   function automatic req_type make_item(op_type op, int am, int ae, int bm, int be);
      req_type r;
      r.operation  = op;
      r.a_mantissa = am[15:0];
      r.a_exponent = ae[7:0];
      r.b_mantissa = bm[15:0];
      r.b_exponent = be[7:0];
      return r;
   endfunction

   task automatic add_row(op_type op, int am, int ae, int bm, int be,
                          bit known = 0, int rm = 0, int re = 0);
      vector_row v;
      v.item   = make_item(op, am, ae, bm, be);
      v.known  = known;
      v.answer.result_mantissa = rm[15:0];
      v.answer.result_exponent = re[7:0];
      vectors.push_back(v);
   endtask

   // Random operand pair; biased toward extremes and near-equal exponents.
   function automatic req_type random_item();
      req_type r;
      int      pick;
      r.operation  = op_type'($urandom_range(0, 1));
      r.a_mantissa = 16'($urandom);
      r.a_exponent = 8'($urandom);
      r.b_mantissa = 16'($urandom);
      r.b_exponent = 8'($urandom);
      pick = $urandom_range(0, 9);
      if (pick == 0) r.a_mantissa = 16'sh8000;
      if (pick == 1) r.b_mantissa = 16'sh7fff;
      if (pick == 2) r.a_exponent = 8'sh7f;
      if (pick == 3) r.b_exponent = 8'sh80;
      if (pick >= 6) r.b_exponent = 8'(r.a_exponent + $urandom_range(0, 20) - 10);
      return r;
   endfunction

   // Drop valid only while idling, so back-to-back items keep it high.
   task automatic send_item(req_type r);
      while ($urandom_range(1, 100) <= send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_results.push_back(compute_mul_add(r));
   endtask

   // Receiver: random back-pressure, compare every accepted item.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected item", 1, 0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_ch.payload.result_mantissa !== want.result_mantissa)
                  report_mismatch("result_mantissa", rsp_ch.payload.result_mantissa,
                                  want.result_mantissa);
               if (rsp_ch.payload.result_exponent !== want.result_exponent)
                  report_mismatch("result_exponent", rsp_ch.payload.result_exponent,
                                  want.result_exponent);
            end
         end
         rsp_ch.ready <= ($urandom_range(1, 100) > recv_idle_pct);
      end
   end

   initial begin
      int n;
      error_count    = 0;
      send_idle_pct  = 12;
      recv_idle_pct  = 88;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Typed-in answers for the plain and extreme cases.
      add_row(OP_MUL, 0, 0, 0, 0, 1, 0, 0);
      add_row(OP_MUL, 3, 2, 5, 1, 1, 15, 3);
      add_row(OP_ADD, 3, 0, 4, 0, 1, 7, 0);
      // Exponent wrap: 127 + 1 gives -128.
      add_row(OP_MUL, 1, 127, 1, 1, 1, 1, -128);
      add_row(OP_MUL, 1, -128, 1, -128, 1, 1, 0);
      // Most negative mantissa halves once.
      add_row(OP_ADD, -32768, 5, 0, 5, 1, -16384, 6);
      add_row(OP_MUL, -32768, 0, -32768, 0, 1, 16384, 16);
      add_row(OP_MUL, 32767, 0, 32767, 0);
      add_row(OP_MUL, -32768, 0, 32767, 0);
      add_row(OP_ADD, 32767, 0, 32767, 0, 1, 32767, 1);
      add_row(OP_ADD, -32768, 0, -32768, 0, 1, -16384, 2);
      add_row(OP_ADD, 32767, 127, 1, 127, 1, 16384, -128);
      // Large alignment shift zeroes the smaller operand.
      add_row(OP_ADD, 100, 20, 32767, 4, 1, 100, 20);
      add_row(OP_ADD, 32767, 127, -32768, -128, 1, 32767, 127);
      add_row(OP_ADD, -5, 0, 0, 1, 1, -2, 1);
      add_row(OP_ADD, 9, 0, 100, 3);
      add_row(OP_ADD, -32768, 0, 1, 15);
      add_row(OP_MUL, -1, 127, -1, 127);
      add_row(OP_MUL, 12345, -100, -2, 50);
      foreach (vectors[i]) begin
         if (vectors[i].known &&
             compute_mul_add(vectors[i].item) != vectors[i].answer)
            report_mismatch("table row", i, -1);
         send_item(vectors[i].item);
      end

      // Hold off until the pipe drains at least once.
      req_ch.valid <= 1'b0;
      wait (pending_results.size() == 0);

      for (n = 0; n < 500; n++) begin
         if (n == 170) begin
            send_idle_pct = 88;
            recv_idle_pct = 12;
         end
         if (n == 340) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (n == 400) begin
            req_ch.valid <= 1'b0;
            wait (pending_results.size() == 0);
         end
         send_item(random_item());
      end
      req_ch.valid <= 1'b0;

      wait (pending_results.size() == 0);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("[float24_mul_add_unit] OK");
      end else begin
         $display("[float24_mul_add_unit] ERROR");
      end
      $finish;
   end

endmodule
